FILE: rtl/core/pcf_pkg.sv
// pcf_pkg: types, constants and CRC helpers shared by the PNG chunk framer.
// No dependencies; used by pcf_front, pcf_cmd_q, pcf_back and png_chunk_framer.
package pcf_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // Request action codes
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_DATA  = 1'b1;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_DATA  = 2'd1,
      CMD_ERR   = 2'd2
   } cmd_kind_type;

   // Classified work for the back end
   typedef struct packed {
      cmd_kind_type kind;
      logic         zero_len;   // start with no data bytes
      logic         last_data;  // data byte that closes the chunk
      logic [30:0]  length;
      logic [31:0]  ctype;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       chunk_done;
      logic       error;
   } rsp_type;

   // Reflected CRC-32, one byte folded in
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Big-endian byte pick: sel 0 gives bits 31..24
   function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] sel);
      logic [7:0] r;
      case (sel)
         2'd0: r = w[31:24];
         2'd1: r = w[23:16];
         2'd2: r = w[15:8];
         default: r = w[7:0];
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/core/pcf_front.sv
// pcf_front: accepts request beats, tracks chunk sequencing, classifies each
// beat into a command for the back end. Depends on pcf_pkg.
module pcf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_action,
   input  logic [30:0]      req_chunk_length,
   input  logic [31:0]      req_chunk_type,
   input  logic [7:0]       req_data_byte,
   input  logic             q_full,
   output logic             cmd_push,
   output pcf_pkg::cmd_type cmd
);

   logic        chunk_open_ff, chunk_open_in;
   logic [30:0] bytes_left_ff, bytes_left_in;
   logic [30:0] left_dec;
   logic        accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign cmd_push = accept;
   assign left_dec = bytes_left_ff - 31'd1;

   always_comb begin
      chunk_open_in = chunk_open_ff;
      bytes_left_in = bytes_left_ff;
      cmd.kind      = pcf_pkg::CMD_ERR;
      cmd.zero_len  = (req_chunk_length == 31'd0);
      cmd.last_data = (left_dec == 31'd0);
      cmd.length    = req_chunk_length;
      cmd.ctype     = req_chunk_type;
      cmd.data      = req_data_byte;
      if (req_action == pcf_pkg::ACT_START) begin
         if (!chunk_open_ff) begin
            cmd.kind      = pcf_pkg::CMD_START;
            chunk_open_in = (req_chunk_length != 31'd0);
            bytes_left_in = req_chunk_length;
         end
      end else if (chunk_open_ff) begin
         cmd.kind      = pcf_pkg::CMD_DATA;
         chunk_open_in = (left_dec != 31'd0);
         bytes_left_in = left_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_open_ff <= 1'b0;
         bytes_left_ff <= '0;
      end else if (accept) begin
         chunk_open_ff <= chunk_open_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   a_err_no_change: assert property (@(posedge clock) disable iff (reset)
      accept && cmd.kind == pcf_pkg::CMD_ERR |=>
         $stable(chunk_open_ff) && $stable(bytes_left_ff))
      else $error("out-of-sequence beat changed chunk state");

   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      !chunk_open_ff |-> bytes_left_ff == 31'd0)
      else $error("closed chunk with bytes outstanding");

endmodule

FILE: rtl/core/pcf_cmd_q.sv
// pcf_cmd_q: short command queue between front and back end.
// Depends on pcf_pkg for the command type.
module pcf_cmd_q #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pcf_pkg::cmd_type wr_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output pcf_pkg::cmd_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pcf_pkg::cmd_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               do_pop;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         if (do_pop) rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         if (push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (!push && do_pop) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue written while full");

endmodule

FILE: rtl/core/pcf_back.sv
// pcf_back: sequences each command into output bytes, keeps the running CRC,
// and holds a two-entry result queue. Depends on pcf_pkg.
module pcf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  pcf_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pcf_pkg::rsp_type rsp
);

   logic [3:0]       beat_ff, beat_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      crc_word;
   logic [3:0]       dsel;
   logic [7:0]       tb;
   logic             finish, emit, space, do_pop;
   pcf_pkg::rsp_type beat;

   pcf_pkg::rsp_type mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff;

   assign crc_word = ~crc_ff;
   assign dsel     = beat_ff - 4'd1;
   assign tb       = pcf_pkg::byte_of(cmd.ctype, beat_ff[1:0]);

   // beat numbering: start 0-3 length, 4-7 type, 8-11 CRC;
   // data 0 byte, 1-4 CRC
   always_comb begin
      beat     = '0;
      finish   = 1'b0;
      crc_in   = crc_ff;
      case (cmd.kind)
         pcf_pkg::CMD_START: begin
            if (beat_ff < 4'd4) begin
               beat.out_byte = pcf_pkg::byte_of({1'b0, cmd.length}, beat_ff[1:0]);
            end else if (beat_ff < 4'd8) begin
               beat.out_byte = tb;
               crc_in = pcf_pkg::crc32_byte((beat_ff == 4'd4) ? pcf_pkg::CRC_INIT : crc_ff, tb);
               if (beat_ff == 4'd7) begin
                  beat.run_last = !cmd.zero_len;
                  finish        = !cmd.zero_len;
               end
            end else begin
               beat.out_byte = pcf_pkg::byte_of(crc_word, beat_ff[1:0]);
               if (beat_ff == 4'd11) begin
                  beat.run_last   = 1'b1;
                  beat.chunk_done = 1'b1;
                  finish          = 1'b1;
                  crc_in          = pcf_pkg::CRC_INIT;
               end
            end
         end
         pcf_pkg::CMD_DATA: begin
            if (beat_ff == 4'd0) begin
               beat.out_byte = cmd.data;
               crc_in        = pcf_pkg::crc32_byte(crc_ff, cmd.data);
               beat.run_last = !cmd.last_data;
               finish        = !cmd.last_data;
            end else begin
               beat.out_byte = pcf_pkg::byte_of(crc_word, dsel[1:0]);
               if (beat_ff == 4'd4) begin
                  beat.run_last   = 1'b1;
                  beat.chunk_done = 1'b1;
                  finish          = 1'b1;
                  crc_in          = pcf_pkg::CRC_INIT;
               end
            end
         end
         default: begin
            beat.error    = 1'b1;
            beat.run_last = 1'b1;
            finish        = 1'b1;
         end
      endcase
   end

   assign do_pop    = rsp_pop && (cnt_ff != 2'd0);
   assign space     = (cnt_ff != 2'd2) || do_pop;
   assign emit      = cmd_valid && space;
   assign cmd_pop   = emit && finish;
   assign beat_in   = finish ? 4'd0 : beat_ff + 4'd1;
   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp       = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (emit) begin
         mem_ff[wr_ptr_ff] <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff   <= '0;
         crc_ff    <= pcf_pkg::CRC_INIT;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (emit) begin
            beat_ff   <= beat_in;
            crc_ff    <= crc_in;
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         if (emit && !do_pop) cnt_ff <= cnt_ff + 2'd1;
         else if (!emit && do_pop) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      emit && beat.chunk_done |-> beat.run_last && finish)
      else $error("chunk_done beat does not end its command");

   a_pop_needs_emit: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid && space)
      else $error("command retired without a beat");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

endmodule

FILE: rtl/core/png_chunk_framer.sv
// png_chunk_framer: top level of the PNG chunk framer with CRC-32.
// Depends on pcf_pkg, pcf_front, pcf_cmd_q and pcf_back.
//
// A start beat (action 0) emits the 4-byte big-endian length and the 4 type
// bytes, plus the 4 CRC bytes at once when the length is zero; a data beat
// (action 1) emits its byte, plus the 4 CRC bytes on the last byte of the
// chunk. Out-of-sequence beats give one error result and leave state alone.
// The front end accepts one request beat per cycle while its command queue
// (CMD_Q_DEPTH entries) has room; the back end emits one result byte per
// cycle while the result queue has room; a data beat gives 1 byte (5 when it
// closes the chunk), a start 8 or 12 bytes, an error 1. The two-beat result
// queue takes a new byte in the same cycle one is popped. No clearing pass after reset.
module png_chunk_framer #(
   parameter int CMD_Q_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_action,
   input  logic [30:0] req_chunk_length,
   input  logic [31:0] req_chunk_type,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_chunk_done,
   output logic        rsp_error
);

   pcf_pkg::cmd_type wr_cmd, head;
   pcf_pkg::rsp_type rsp;
   logic             cmd_push, q_full, head_valid, cmd_pop;

   pcf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_action       (req_action),
      .req_chunk_length (req_chunk_length),
      .req_chunk_type   (req_chunk_type),
      .req_data_byte    (req_data_byte),
      .q_full           (q_full),
      .cmd_push         (cmd_push),
      .cmd              (wr_cmd)
   );

   pcf_cmd_q #(
      .DEPTH (CMD_Q_DEPTH)
   ) u_cmd_q (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .wr_cmd     (wr_cmd),
      .full       (q_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   pcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_out_byte   = rsp.out_byte;
   assign rsp_run_last   = rsp.run_last;
   assign rsp_chunk_done = rsp.chunk_done;
   assign rsp_error      = rsp.error;

endmodule

FILE: dv/tb_png_chunk_framer.sv
`timescale 1ns / 1ps
// tb_png_chunk_framer: self-checking bench for the PNG chunk framer with CRC-32.
// Depends on pcf_pkg and png_chunk_framer; a scoreboard class predicts the
// framed byte stream, plain tasks drive the request queue with random gaps.
module tb_png_chunk_framer;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   // Predicts the framed stream and checks each result beat against it
   class chunk_frame_board;
      pcf_pkg::rsp_type framed_bytes_due[$];
      logic [31:0] crc_reg;
      logic [30:0] bytes_remaining;
      bit          in_chunk;
      int unsigned fault_count;

      function new();
         crc_reg = '1;
         bytes_remaining = '0;
         in_chunk = 1'b0;
         fault_count = 0;
      endfunction

      function logic [31:0] fold_crc(input logic [31:0] c, input logic [7:0] b);
         logic [31:0] r;
         r = c ^ {24'd0, b};
         for (int i = 0; i < 8; i++) begin
            if (r[0]) r = (r >> 1) ^ 32'hEDB88320;
            else r = r >> 1;
         end
         return r;
      endfunction

      function void due(input logic [7:0] b, input bit last, input bit done, input bit err);
         pcf_pkg::rsp_type r;
         r.out_byte = b;
         r.run_last = last;
         r.chunk_done = done;
         r.error = err;
         framed_bytes_due = {framed_bytes_due, r};
      endfunction

      function void close_chunk();
         logic [31:0] c;
         c = ~crc_reg;
         for (int i = 0; i < 4; i++) begin
            due(c[31 - 8 * i -: 8], i == 3, i == 3, 1'b0);
         end
         in_chunk = 1'b0;
         bytes_remaining = '0;
         crc_reg = '1;
      endfunction

      // Called once per accepted request beat
      function void frame_request(input bit act, input logic [30:0] len,
                                  input logic [31:0] ctype, input logic [7:0] dat);
         logic [31:0] len_word;
         logic [7:0]  tb;
         if (act == pcf_pkg::ACT_START) begin
            if (in_chunk) begin
               due(8'd0, 1'b1, 1'b0, 1'b1);
            end else begin
               len_word = {1'b0, len};
               for (int i = 0; i < 4; i++) begin
                  due(len_word[31 - 8 * i -: 8], 1'b0, 1'b0, 1'b0);
               end
               crc_reg = '1;
               for (int i = 0; i < 4; i++) begin
                  tb = ctype[31 - 8 * i -: 8];
                  crc_reg = fold_crc(crc_reg, tb);
                  due(tb, (i == 3) && (len != 0), 1'b0, 1'b0);
               end
               in_chunk = 1'b1;
               bytes_remaining = len;
               if (len == 0) close_chunk();
            end
         end else if (!in_chunk) begin
            due(8'd0, 1'b1, 1'b0, 1'b1);
         end else begin
            crc_reg = fold_crc(crc_reg, dat);
            bytes_remaining = bytes_remaining - 31'd1;
            if (bytes_remaining == 0) begin
               due(dat, 1'b0, 1'b0, 1'b0);
               close_chunk();
            end else begin
               due(dat, 1'b1, 1'b0, 1'b0);
            end
         end
      endfunction

      function void note_fault(input string msg);
         fault_count++;
         if (fault_count <= MAX_REPORTS) $display("%s", msg);
      endfunction

      function void match_beat(input pcf_pkg::rsp_type got);
         pcf_pkg::rsp_type want;
         if (framed_bytes_due.size() == 0) begin
            note_fault($sformatf("unexpected beat: byte %02h last %0b done %0b err %0b",
                                 got.out_byte, got.run_last, got.chunk_done, got.error));
            return;
         end
         want = framed_bytes_due.pop_front();
         if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
             got.chunk_done !== want.chunk_done || got.error !== want.error)
            note_fault($sformatf({"mismatch: exp byte %02h last %0b done %0b err %0b, ",
                                  "got byte %02h last %0b done %0b err %0b"},
                                 want.out_byte, want.run_last, want.chunk_done, want.error,
                                 got.out_byte, got.run_last, got.chunk_done, got.error));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_action;
   logic [30:0] req_chunk_length;
   logic [31:0] req_chunk_type;
   logic [7:0]  req_data_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_chunk_done;
   logic        rsp_error;

   chunk_frame_board frame_board = new();
   bit idle_on;
   int items_sent;

   png_chunk_framer dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_action       (req_action),
      .req_chunk_length (req_chunk_length),
      .req_chunk_type   (req_chunk_type),
      .req_data_byte    (req_data_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_chunk_done   (rsp_chunk_done),
      .rsp_error        (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random pop stalls, check every popped beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            frame_board.match_beat({rsp_out_byte, rsp_run_last, rsp_chunk_done, rsp_error});
         rsp_pop <= idle_on ? ($urandom_range(0, 99) >= 16) : 1'b1;
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_png_chunk_framer failed");
      $finish;
   end

   // Holds push high until the beat is taken, then hands it to the predictor
   task automatic push_item(input bit act, input logic [30:0] len,
                            input logic [31:0] ctype, input logic [7:0] dat);
      if (idle_on && $urandom_range(0, 99) < 16) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_action <= act;
      req_chunk_length <= len;
      req_chunk_type <= ctype;
      req_data_byte <= dat;
      do @(posedge clock); while (req_full);
      frame_board.frame_request(act, len, ctype, dat);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (frame_board.framed_bytes_due.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed chunks with random content, some stray beats
   task automatic run_random(input int target);
      int stop_at;
      int len;
      logic [31:0] ctype;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 8) begin
            // stray data beat, not part of a chunk that this task starts
            push_item(pcf_pkg::ACT_DATA, 31'($urandom), $urandom, 8'($urandom));
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
               ctype = $urandom;
            else
               ctype = {8'($urandom_range(65, 122)), 8'($urandom_range(65, 122)),
                        8'($urandom_range(65, 122)), 8'($urandom_range(65, 122))};
            push_item(pcf_pkg::ACT_START, 31'(len), ctype, 8'($urandom));
            for (int j = 0; j < len; j++) begin
               if ($urandom_range(0, 99) < 5)
                  push_item(pcf_pkg::ACT_START, 31'($urandom), $urandom, 8'($urandom));
               push_item(pcf_pkg::ACT_DATA, 31'($urandom), $urandom, 8'($urandom));
            end
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_push <= 1'b0;
      req_action <= pcf_pkg::ACT_START;
      req_chunk_length <= '0;
      req_chunk_type <= '0;
      req_data_byte <= '0;
      idle_on = 1'b1;
      items_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: stray data, zero-length chunks, edge bytes, start inside a chunk
      push_item(pcf_pkg::ACT_DATA, 31'h7FFFFFFF, 32'hFFFFFFFF, 8'hFF);
      push_item(pcf_pkg::ACT_START, 31'd0, 32'h00000000, 8'hFF);
      push_item(pcf_pkg::ACT_START, 31'd0, 32'hFFFFFFFF, 8'h00);
      push_item(pcf_pkg::ACT_START, 31'd1, 32'h49454E44, 8'h5A);
      push_item(pcf_pkg::ACT_DATA, 31'h7FFFFFFF, 32'hFFFFFFFF, 8'hFF);
      push_item(pcf_pkg::ACT_START, 31'd3, 32'h49444154, 8'h00);
      push_item(pcf_pkg::ACT_START, 31'h7FFFFFFF, 32'hA5A5A5A5, 8'hFF);
      push_item(pcf_pkg::ACT_DATA, 31'd0, 32'd0, 8'h00);
      push_item(pcf_pkg::ACT_DATA, 31'd0, 32'd0, 8'h80);
      push_item(pcf_pkg::ACT_DATA, 31'd0, 32'd0, 8'h7F);
      push_item(pcf_pkg::ACT_START, 31'd2, 32'h74455874, 8'hC3);
      push_item(pcf_pkg::ACT_DATA, 31'h2AAAAAAA, 32'h55555555, 8'hAA);
      push_item(pcf_pkg::ACT_DATA, 31'h55555555, 32'hAAAAAAAA, 8'h55);
      push_item(pcf_pkg::ACT_DATA, 31'h40000000, 32'h80000000, 8'h01);

      // sender holds off until the stream has fully drained
      wait_drained();

      run_random(85);
      idle_on = 1'b0;
      run_random(85);
      idle_on = 1'b1;
      run_random(85);

      // largest length near the end: the chunk can never close within the run
      push_item(pcf_pkg::ACT_START, 31'h7FFFFFFF, 32'h49444154, 8'h00);
      repeat (4) push_item(pcf_pkg::ACT_DATA, 31'($urandom), $urandom, 8'($urandom));
      push_item(pcf_pkg::ACT_START, 31'h40000000, 32'h49454E44, 8'hFF);

      wait_drained();
      repeat (30) @(posedge clock);

      if (frame_board.fault_count == 0)
         $display("tb_png_chunk_framer passed");
      else
         $display("tb_png_chunk_framer failed");
      $finish;
   end

endmodule

FILE: png_chunk_framer.f
rtl/core/pcf_pkg.sv
rtl/core/pcf_front.sv
rtl/core/pcf_cmd_q.sv
rtl/core/pcf_back.sv
rtl/core/png_chunk_framer.sv
dv/tb_png_chunk_framer.sv
